// ===== rtl/core/hcra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_pkg: shared types, constants and step table
// Item and term records, operand and destination codes, and the step table
// that drives the shared 32x32 multiplier of the restraint engine.
// ----------------------------------------------------------------------------
package hcra_pkg;

	// Stream and register port widths
	localparam int unsigned IN_DATA_W  = 176;
	localparam int unsigned OUT_DATA_W = 192;
	localparam int unsigned CFG_IDX_W  = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELL_A = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_C = 8'd1;

	// Reset value of the cell lengths: 1.0 in Q12.20
	localparam logic [31:0] CELL_ONE = 32'h0010_0000;

	// Saturation limits
	localparam logic [62:0] TERM_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG   = 64'h8000_0000_0000_0000;

	// Queue between front and engine
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	// Step sequencer
	localparam int unsigned         STEP_W    = 6;
	localparam logic [STEP_W-1:0]   LAST_STEP = 6'd38;

	// Operand word codes
	localparam int unsigned SRC_W = 5;
	localparam logic [SRC_W-1:0] SRC_ZERO = 5'd0;
	localparam logic [SRC_W-1:0] SRC_MX   = 5'd1;
	localparam logic [SRC_W-1:0] SRC_MY   = 5'd2;
	localparam logic [SRC_W-1:0] SRC_MZ   = 5'd3;
	localparam logic [SRC_W-1:0] SRC_CA   = 5'd4;
	localparam logic [SRC_W-1:0] SRC_CC   = 5'd5;
	localparam logic [SRC_W-1:0] SRC_W_   = 5'd6;
	localparam logic [SRC_W-1:0] SRC_Q0   = 5'd7;
	localparam logic [SRC_W-1:0] SRC_Q1   = 5'd8;
	localparam logic [SRC_W-1:0] SRC_Z0   = 5'd9;
	localparam logic [SRC_W-1:0] SRC_Z1   = 5'd10;
	localparam logic [SRC_W-1:0] SRC_A20  = 5'd11;
	localparam logic [SRC_W-1:0] SRC_A21  = 5'd12;
	localparam logic [SRC_W-1:0] SRC_C20  = 5'd13;
	localparam logic [SRC_W-1:0] SRC_C21  = 5'd14;
	localparam logic [SRC_W-1:0] SRC_M0   = 5'd15;
	localparam logic [SRC_W-1:0] SRC_M1   = 5'd16;
	localparam logic [SRC_W-1:0] SRC_WM0  = 5'd17;
	localparam logic [SRC_W-1:0] SRC_WM1  = 5'd18;
	localparam logic [SRC_W-1:0] SRC_WM2  = 5'd19;
	localparam logic [SRC_W-1:0] SRC_DA0  = 5'd20;
	localparam logic [SRC_W-1:0] SRC_DA1  = 5'd21;
	localparam logic [SRC_W-1:0] SRC_DC0  = 5'd22;
	localparam logic [SRC_W-1:0] SRC_DC1  = 5'd23;

	// Destination codes for the accumulator value
	localparam int unsigned DST_W = 4;
	localparam logic [DST_W-1:0] DST_NONE = 4'd0;
	localparam logic [DST_W-1:0] DST_Q    = 4'd1;
	localparam logic [DST_W-1:0] DST_DZ2  = 4'd2;
	localparam logic [DST_W-1:0] DST_A2   = 4'd3;
	localparam logic [DST_W-1:0] DST_C2   = 4'd4;
	localparam logic [DST_W-1:0] DST_DA   = 4'd5;
	localparam logic [DST_W-1:0] DST_D2   = 4'd6;
	localparam logic [DST_W-1:0] DST_DC   = 4'd7;
	localparam logic [DST_W-1:0] DST_WM   = 4'd8;
	localparam logic [DST_W-1:0] DST_TT   = 4'd9;
	localparam logic [DST_W-1:0] DST_GA   = 4'd10;
	localparam logic [DST_W-1:0] DST_GC   = 4'd11;

	// One restraint after classification
	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic        same_sign;
		logic [47:0] tgt;
		logic [31:0] w;
		logic        last;
	} item_t;

	// Terms of one restraint handed to the accumulators
	typedef struct packed {
		logic [62:0] tt;
		logic [63:0] ga_mag;
		logic [63:0] gc_mag;
		logic        neg;
		logic        ov;
		logic        last;
	} term_t;

	// Control of one multiplier step
	typedef struct packed {
		logic [SRC_W-1:0] src_a;
		logic [SRC_W-1:0] src_b;
		logic [1:0]       shift;
		logic             clr;
		logic             sub_same;
		logic             do_mag;
		logic [DST_W-1:0] dst;
	} ctl_t;

	function automatic ctl_t mk(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
			input logic [1:0] sh, input logic clr, input logic sub, input logic mag,
			input logic [DST_W-1:0] dst);
		ctl_t c;
		c.src_a    = a;
		c.src_b    = b;
		c.shift    = sh;
		c.clr      = clr;
		c.sub_same = sub;
		c.do_mag   = mag;
		c.dst      = dst;
		return c;
	endfunction

	// Step table: product of two words, added at a word offset
	function automatic ctl_t step_ctl(input logic [STEP_W-1:0] step);
		ctl_t c;
		unique case (step)
			// q = dx^2 + dy^2 - dx*dy
			6'd0:  c = mk(SRC_MX,  SRC_MX,  2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd1:  c = mk(SRC_MY,  SRC_MY,  2'd0, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd2:  c = mk(SRC_MX,  SRC_MY,  2'd0, 1'b0, 1'b1, 1'b0, DST_Q);
			// dz^2, a^2, c^2
			6'd3:  c = mk(SRC_MZ,  SRC_MZ,  2'd0, 1'b1, 1'b0, 1'b0, DST_DZ2);
			6'd4:  c = mk(SRC_CA,  SRC_CA,  2'd0, 1'b1, 1'b0, 1'b0, DST_A2);
			6'd5:  c = mk(SRC_CC,  SRC_CC,  2'd0, 1'b1, 1'b0, 1'b0, DST_C2);
			// q*a for the a derivative
			6'd6:  c = mk(SRC_Q0,  SRC_CA,  2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd7:  c = mk(SRC_Q1,  SRC_CA,  2'd1, 1'b0, 1'b0, 1'b0, DST_DA);
			// d2 = q*a^2 + dz^2*c^2
			6'd8:  c = mk(SRC_Q0,  SRC_A20, 2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd9:  c = mk(SRC_Q0,  SRC_A21, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd10: c = mk(SRC_Q1,  SRC_A20, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd11: c = mk(SRC_Q1,  SRC_A21, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd12: c = mk(SRC_Z0,  SRC_C20, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd13: c = mk(SRC_Z0,  SRC_C21, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd14: c = mk(SRC_Z1,  SRC_C20, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd15: c = mk(SRC_Z1,  SRC_C21, 2'd2, 1'b0, 1'b0, 1'b0, DST_D2);
			// dz^2*c for the c derivative, residual alongside
			6'd16: c = mk(SRC_Z0,  SRC_CC,  2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd17: c = mk(SRC_Z1,  SRC_CC,  2'd1, 1'b0, 1'b0, 1'b1, DST_DC);
			// w*|r|
			6'd18: c = mk(SRC_W_,  SRC_M0,  2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd19: c = mk(SRC_W_,  SRC_M1,  2'd1, 1'b0, 1'b0, 1'b0, DST_WM);
			6'd20: c = mk(SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE);
			// w*r^2
			6'd21: c = mk(SRC_WM0, SRC_M0,  2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd22: c = mk(SRC_WM0, SRC_M1,  2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd23: c = mk(SRC_WM1, SRC_M0,  2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd24: c = mk(SRC_WM1, SRC_M1,  2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd25: c = mk(SRC_WM2, SRC_M0,  2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd26: c = mk(SRC_WM2, SRC_M1,  2'd3, 1'b0, 1'b0, 1'b0, DST_TT);
			// w*|r|*da
			6'd27: c = mk(SRC_WM0, SRC_DA0, 2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd28: c = mk(SRC_WM0, SRC_DA1, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd29: c = mk(SRC_WM1, SRC_DA0, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd30: c = mk(SRC_WM1, SRC_DA1, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd31: c = mk(SRC_WM2, SRC_DA0, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd32: c = mk(SRC_WM2, SRC_DA1, 2'd3, 1'b0, 1'b0, 1'b0, DST_GA);
			// w*|r|*dc
			6'd33: c = mk(SRC_WM0, SRC_DC0, 2'd0, 1'b1, 1'b0, 1'b0, DST_NONE);
			6'd34: c = mk(SRC_WM0, SRC_DC1, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd35: c = mk(SRC_WM1, SRC_DC0, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd36: c = mk(SRC_WM1, SRC_DC1, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd37: c = mk(SRC_WM2, SRC_DC0, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE);
			6'd38: c = mk(SRC_WM2, SRC_DC1, 2'd3, 1'b0, 1'b0, 1'b0, DST_GC);
			default: c = mk(SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE);
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/hcra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_front: restraint intake
// Unpacks the input word, takes the magnitudes of the offsets and the sign
// relation of dx and dy, and pushes the record into the queue.
// ----------------------------------------------------------------------------
module hcra_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata: offset_x[31:0], offset_y[63:32], offset_z[95:64],
	// target_sq_dist[143:96], weight[175:144]
	input  logic [hcra_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	input  logic                             q_full,
	output logic                             q_push,
	output hcra_pkg::item_t                  q_item
);

	logic [31:0] dx, dy, dz;

	// Split the word into fields
	assign dx = s_tdata[31:0];
	assign dy = s_tdata[63:32];
	assign dz = s_tdata[95:64];

	// Accept whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Magnitudes and sign relation for the engine
	always_comb begin
		q_item.mx        = dx[31] ? (32'd0 - dx) : dx;
		q_item.my        = dy[31] ? (32'd0 - dy) : dy;
		q_item.mz        = dz[31] ? (32'd0 - dz) : dz;
		q_item.same_sign = (dx[31] == dy[31]);
		q_item.tgt       = s_tdata[143:96];
		q_item.w         = s_tdata[175:144];
		q_item.last      = s_tlast;
	end

endmodule

// ===== rtl/core/hcra_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_queue: two-entry restraint queue
// Decouples the intake from the engine so each side can stall on its own.
// ----------------------------------------------------------------------------
module hcra_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hcra_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output hcra_pkg::item_t pop_item
);

	hcra_pkg::item_t                   ent_q [hcra_pkg::QUEUE_DEPTH];
	logic [hcra_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [hcra_pkg::QCNT_W-1:0]       cnt_q;

	assign full     = (cnt_q == hcra_pkg::QCNT_W'(hcra_pkg::QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = ent_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/hcra_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_engine: restraint term engine
// Runs one restraint at a time through a shared 32x32 multiplier and a
// 160-bit accumulator, following the step table, and hands the target and
// gradient terms to the accumulators.
// ----------------------------------------------------------------------------
module hcra_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  hcra_pkg::item_t item,
	output logic            item_pop,
	input  logic [31:0]     cell_a,
	input  logic [31:0]     cell_c,
	output logic            term_valid,
	input  logic            term_ready,
	output hcra_pkg::term_t term
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	typedef struct packed {
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] mz;
		logic [31:0] ca;
		logic [31:0] cc;
		logic [31:0] w;
		logic [63:0] q;
		logic [63:0] dz2;
		logic [63:0] a2;
		logic [63:0] c2;
		logic [63:0] mag;
		logic [95:0] wm;
		logic [63:0] da;
		logic [63:0] dc;
	} ops_t;

	function automatic logic [31:0] word_of(input ops_t ops,
			input logic [hcra_pkg::SRC_W-1:0] code);
		logic [31:0] r;
		unique case (code)
			hcra_pkg::SRC_MX:  r = ops.mx;
			hcra_pkg::SRC_MY:  r = ops.my;
			hcra_pkg::SRC_MZ:  r = ops.mz;
			hcra_pkg::SRC_CA:  r = ops.ca;
			hcra_pkg::SRC_CC:  r = ops.cc;
			hcra_pkg::SRC_W_:  r = ops.w;
			hcra_pkg::SRC_Q0:  r = ops.q[31:0];
			hcra_pkg::SRC_Q1:  r = ops.q[63:32];
			hcra_pkg::SRC_Z0:  r = ops.dz2[31:0];
			hcra_pkg::SRC_Z1:  r = ops.dz2[63:32];
			hcra_pkg::SRC_A20: r = ops.a2[31:0];
			hcra_pkg::SRC_A21: r = ops.a2[63:32];
			hcra_pkg::SRC_C20: r = ops.c2[31:0];
			hcra_pkg::SRC_C21: r = ops.c2[63:32];
			hcra_pkg::SRC_M0:  r = ops.mag[31:0];
			hcra_pkg::SRC_M1:  r = ops.mag[63:32];
			hcra_pkg::SRC_WM0: r = ops.wm[31:0];
			hcra_pkg::SRC_WM1: r = ops.wm[63:32];
			hcra_pkg::SRC_WM2: r = ops.wm[95:64];
			hcra_pkg::SRC_DA0: r = ops.da[31:0];
			hcra_pkg::SRC_DA1: r = ops.da[63:32];
			hcra_pkg::SRC_DC0: r = ops.dc[31:0];
			hcra_pkg::SRC_DC1: r = ops.dc[63:32];
			default:           r = '0;
		endcase
		return r;
	endfunction

	// Gradient magnitude: bits from 2^-47 up, clamped to the int64 limit
	function automatic logic [64:0] grad_clamp(input logic [159:0] p, input logic neg);
		logic        hi;
		logic [63:0] lo;
		logic [63:0] lim;
		logic        over;
		hi   = |p[159:111];
		lo   = p[110:47];
		lim  = neg ? hcra_pkg::NEG_MAG : hcra_pkg::POS_MAX;
		over = hi || (lo > lim);
		return {over, (over ? lim : lo)};
	endfunction

	logic [1:0]                  state_q;
	logic [hcra_pkg::STEP_W-1:0] step_q;
	logic                        valid_s1;
	hcra_pkg::ctl_t              ctl, ctl_s1;
	logic [63:0]                 prod_s1;
	logic                        issue;
	ops_t                        ops;
	logic [31:0]                 word_a, word_b;

	// Current restraint
	logic [31:0] mx_q, my_q, mz_q, w_q;
	logic [47:0] tgt_q;
	logic        same_q, last_q;

	// Intermediate values
	logic [159:0] acc_q, acc_base, addend, acc_next;
	logic [63:0]  q_q, dz2_q, a2_q, c2_q, d2_q, da_q, dc_q, mag_q;
	logic [95:0]  wm_q;
	logic         neg_q;
	logic [55:0]  tgt_wide;
	logic [63:0]  diff_pos, diff_neg;

	// Terms
	logic [62:0]  tt_q;
	logic [63:0]  ga_q, gc_q;
	logic         tt_ov_q, ga_ov_q, gc_ov_q;
	logic [64:0]  grad_next;

	assign issue    = (state_q == ST_RUN);
	assign ctl      = hcra_pkg::step_ctl(step_q);
	assign item_pop = (state_q == ST_IDLE) && item_valid;

	// Gather operand words
	always_comb begin
		ops.mx  = mx_q;
		ops.my  = my_q;
		ops.mz  = mz_q;
		ops.ca  = cell_a;
		ops.cc  = cell_c;
		ops.w   = w_q;
		ops.q   = q_q;
		ops.dz2 = dz2_q;
		ops.a2  = a2_q;
		ops.c2  = c2_q;
		ops.mag = mag_q;
		ops.wm  = wm_q;
		ops.da  = da_q;
		ops.dc  = dc_q;
	end

	assign word_a = word_of(ops, ctl.src_a);
	assign word_b = word_of(ops, ctl.src_b);

	// Place the product at its word offset and add or subtract
	always_comb begin
		acc_base = ctl_s1.clr ? '0 : acc_q;
		case (ctl_s1.shift)
			2'd0:    addend = {96'd0, prod_s1};
			2'd1:    addend = {64'd0, prod_s1, 32'd0};
			2'd2:    addend = {32'd0, prod_s1, 64'd0};
			default: addend = {prod_s1, 96'd0};
		endcase
		acc_next = (ctl_s1.sub_same && same_q) ? (acc_base - addend) : (acc_base + addend);
	end

	assign grad_next = grad_clamp(acc_next, neg_q);

	// Residual: d2 against the target widened to Q32.32
	assign tgt_wide = {tgt_q, 8'd0};
	assign diff_pos = d2_q - {8'd0, tgt_wide};
	assign diff_neg = {8'd0, tgt_wide} - d2_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == hcra_pkg::LAST_STEP) begin
						state_q <= ST_FLUSH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (term_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the restraint, multiply, accumulate and store
	always_ff @(posedge clk) begin
		if (item_pop) begin
			mx_q   <= item.mx;
			my_q   <= item.my;
			mz_q   <= item.mz;
			same_q <= item.same_sign;
			tgt_q  <= item.tgt;
			w_q    <= item.w;
			last_q <= item.last;
		end
		if (issue) begin
			prod_s1 <= 64'(word_a) * 64'(word_b);
			ctl_s1  <= ctl;
			if (ctl.do_mag) begin
				neg_q <= (d2_q < {8'd0, tgt_wide});
				mag_q <= (d2_q < {8'd0, tgt_wide}) ? diff_neg : diff_pos;
			end
		end
		if (valid_s1) begin
			acc_q <= acc_next;
			unique case (ctl_s1.dst)
				hcra_pkg::DST_NONE: ;
				hcra_pkg::DST_Q:    q_q   <= acc_next[63:0];
				hcra_pkg::DST_DZ2:  dz2_q <= acc_next[63:0];
				hcra_pkg::DST_A2:   a2_q  <= acc_next[63:0];
				hcra_pkg::DST_C2:   c2_q  <= acc_next[63:0];
				hcra_pkg::DST_DA:   da_q  <= acc_next[106:43];
				hcra_pkg::DST_D2:   d2_q  <= acc_next[127:64];
				hcra_pkg::DST_DC:   dc_q  <= acc_next[106:43];
				hcra_pkg::DST_WM:   wm_q  <= acc_next[95:0];
				hcra_pkg::DST_TT: begin
					tt_ov_q <= |acc_next[159:111];
					tt_q    <= (|acc_next[159:111]) ? hcra_pkg::TERM_MAX : acc_next[110:48];
				end
				hcra_pkg::DST_GA: begin
					ga_ov_q <= grad_next[64];
					ga_q    <= grad_next[63:0];
				end
				hcra_pkg::DST_GC: begin
					gc_ov_q <= grad_next[64];
					gc_q    <= grad_next[63:0];
				end
				default: ;
			endcase
		end
	end

	// Hand over the finished terms
	assign term_valid = (state_q == ST_DONE);
	always_comb begin
		term.tt     = tt_q;
		term.ga_mag = ga_q;
		term.gc_mag = gc_q;
		term.neg    = neg_q;
		term.ov     = tt_ov_q || ga_ov_q || gc_ov_q;
		term.last   = last_q;
	end

endmodule

// ===== rtl/core/hcra_sums.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_sums: saturating set accumulators and result register
// Signs the gradient terms, adds all three terms with saturation, and on the
// last restraint of a set loads the result word and clears the sums.
// ----------------------------------------------------------------------------
module hcra_sums (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              term_valid,
	output logic                              term_ready,
	input  hcra_pkg::term_t                   term,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata: target_sum[62:0], grad_a[126:63], grad_c[190:127], zero[191]
	output logic [hcra_pkg::OUT_DATA_W-1:0]   m_tdata,
	// tuser: overflow[0]
	output logic                              m_tuser
);

	// Signed saturating add: {overflow, sum}
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		logic        over;
		s    = a + b;
		over = (a[63] == b[63]) && (s[63] != a[63]);
		return {over, (over ? (a[63] ? hcra_pkg::NEG_MAG : hcra_pkg::POS_MAX) : s)};
	endfunction

	logic        valid_s1, last_s1, ov_s1;
	logic [62:0] t_s1;
	logic [63:0] ga_s1, gc_s1;
	logic        adv;

	logic [62:0] acc_t_q;
	logic [63:0] acc_a_q, acc_c_q;
	logic        sat_q;

	logic        out_valid_q, out_ov_q;
	logic [62:0] out_t_q;
	logic [63:0] out_a_q, out_c_q;

	logic [63:0] sum_t;
	logic        ov_t;
	logic [62:0] new_t;
	logic [64:0] add_a, add_c;
	logic        sat_next;

	// A last term waits until the result register is free
	assign adv        = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign term_ready = !valid_s1 || adv;

	// Saturating sums
	assign sum_t    = {1'b0, acc_t_q} + {1'b0, t_s1};
	assign ov_t     = sum_t[63];
	assign new_t    = ov_t ? hcra_pkg::TERM_MAX : sum_t[62:0];
	assign add_a    = sat_add(acc_a_q, ga_s1);
	assign add_c    = sat_add(acc_c_q, gc_s1);
	assign sat_next = sat_q || ov_s1 || ov_t || add_a[64] || add_c[64];

	// Control and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_t_q     <= '0;
			acc_a_q     <= '0;
			acc_c_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (term_valid && term_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				if (last_s1) begin
					acc_t_q <= '0;
					acc_a_q <= '0;
					acc_c_q <= '0;
					sat_q   <= 1'b0;
				end else begin
					acc_t_q <= new_t;
					acc_a_q <= add_a[63:0];
					acc_c_q <= add_c[63:0];
					sat_q   <= sat_next;
				end
			end
			if (adv && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sign the terms, load the result word
	always_ff @(posedge clk) begin
		if (term_valid && term_ready) begin
			t_s1    <= term.tt;
			ga_s1   <= term.neg ? (64'd0 - term.ga_mag) : term.ga_mag;
			gc_s1   <= term.neg ? (64'd0 - term.gc_mag) : term.gc_mag;
			ov_s1   <= term.ov;
			last_s1 <= term.last;
		end
		if (adv && last_s1) begin
			out_t_q  <= new_t;
			out_a_q  <= add_a[63:0];
			out_c_q  <= add_c[63:0];
			out_ov_q <= sat_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_c_q, out_a_q, out_t_q};
	assign m_tuser  = out_ov_q;

endmodule

// ===== rtl/core/hexagonal_cell_restraint_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexagonal_cell_restraint_accumulator: hexagonal cell restraint sums
// Accumulates weighted squared residuals of distance restraints and their
// derivatives with respect to the hexagonal cell lengths a and c.
// ----------------------------------------------------------------------------
// Usage:
//   Write cell_a (index 0) and cell_c (index 1) on the cfg channel while the
//   block is idle; cfg_ready is always high. Unknown indexes are dropped.
//   Stream restraints on s_*; s_tlast marks the last restraint of a set.
//   Only the last restraint of a set produces a word on m_*: the three
//   saturated sums in m_tdata and the saturation flag in m_tuser; the sums
//   then clear for the next set.
// Engine:
//   Each restraint runs 39 steps through the one shared 32x32 multiplier,
//   plus pop, flush and hand-over states in the engine.
//   A two-entry queue takes new restraints while the engine works.
// Reset and stall:
//   Reset sets both cell lengths to 1.0 and clears sums, queue and flag.
//   A result waits in the output register while m_tready is low; the engine
//   keeps working on non-last restraints and holds only at the next last one.
// ----------------------------------------------------------------------------
module hexagonal_cell_restraint_accumulator (
	input  logic                              clk,
	input  logic                              arst_n,
	// Restraint stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata: offset_x[31:0], offset_y[63:32], offset_z[95:64],
	// target_sq_dist[143:96], weight[175:144]
	input  logic [hcra_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata: target_sum[62:0], grad_a[126:63], grad_c[190:127], zero[191]
	output logic [hcra_pkg::OUT_DATA_W-1:0]   m_tdata,
	// tuser: overflow[0]
	output logic                              m_tuser,
	// Register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hcra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	logic [31:0]     cell_a_q, cell_c_q;
	logic            q_push, q_full, q_pop, q_valid;
	hcra_pkg::item_t push_item, pop_item;
	logic            term_valid, term_ready;
	hcra_pkg::term_t term;

	// Register writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_a_q <= hcra_pkg::CELL_ONE;
			cell_c_q <= hcra_pkg::CELL_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hcra_pkg::REG_CELL_A: cell_a_q <= cfg_data;
				hcra_pkg::REG_CELL_C: cell_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hcra_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	hcra_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	hcra_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (pop_item),
		.item_pop   (q_pop),
		.cell_a     (cell_a_q),
		.cell_c     (cell_c_q),
		.term_valid (term_valid),
		.term_ready (term_ready),
		.term       (term)
	);

	hcra_sums u_sums (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term_valid),
		.term_ready (term_ready),
		.term       (term),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== sim/hcra_sums_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcra_sums_checker: restraint sum predictor and result comparison
// Watches the register, restraint and result channels of the hexagonal cell
// restraint accumulator. It folds each accepted restraint into its own copy
// of the three sums and the saturation flag. On the last restraint of a set
// it queues the expected sums and compares them with the next result word.
// ----------------------------------------------------------------------------
module hcra_sums_checker
	import hcra_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    s_tlast,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [OUT_DATA_W-1:0]   m_tdata,
	input  logic                    m_tuser,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]             cfg_data,
	output int                      failures,
	output int                      outstanding
);

	typedef struct packed {
		logic [62:0]        target_sum;
		logic signed [63:0] grad_a;
		logic signed [63:0] grad_c;
		logic               overflow;
	} set_sums_t;

	// Cell lengths as last written, and the running sums of the open set
	logic [31:0] cell_a;
	logic [31:0] cell_c;
	logic [63:0] sum_target;
	logic [63:0] sum_grad_a;
	logic [63:0] sum_grad_c;
	logic        sat_flag;

	set_sums_t   expected_sums[$];

	// Signed add with clamping at the int64 limits
	function automatic logic [63:0] clamp_add(input logic [63:0] acc,
			input logic [63:0] term, inout logic ov);
		logic signed [64:0] total;
		total = $signed({acc[63], acc}) + $signed({term[63], term});
		if (total[64] != total[63]) begin
			ov = 1'b1;
			return total[64] ? NEG_MAG : POS_MAX;
		end
		return total[63:0];
	endfunction

	// Gradient term: sign of the residual, magnitude floor(2*w*|r|*deriv)
	function automatic logic [63:0] slope_term(input logic [191:0] w_mag,
			input logic [63:0] deriv, input logic neg, inout logic ov);
		logic [191:0] prod;
		logic [63:0]  lim;
		prod = w_mag * deriv;
		prod = prod >> 47;
		lim  = neg ? NEG_MAG : POS_MAX;
		if (prod > lim) begin
			ov   = 1'b1;
			prod = lim;
		end
		return neg ? 64'd0 - prod[63:0] : prod[63:0];
	endfunction

	// Fold one restraint into the sums; return 1 with the sums on a last one
	function automatic logic fold_restraint(input logic [31:0] off_x,
			input logic [31:0] off_y, input logic [31:0] off_z,
			input logic [47:0] target, input logic [31:0] weight,
			input logic last, output set_sums_t sums);
		logic signed [31:0] dx, dy, dz;
		logic signed [65:0] ex, ey, ez, metric, dz_sq;
		logic [63:0]        q, dz2, a2, c2, d2, tgt, mag, da, dc, term;
		logic [191:0]       wide, w_mag;
		logic               neg, ov;
		dx = off_x;
		dy = off_y;
		dz = off_z;
		ex = dx;
		ey = dy;
		ez = dz;
		ov = 1'b0;
		sums = '0;

		// metric factor and squared distance, Q32.32 floored
		metric = ex * ex + ey * ey - ex * ey;
		dz_sq  = ez * ez;
		q      = metric[63:0];
		dz2    = dz_sq[63:0];
		a2     = cell_a * cell_a;
		c2     = cell_c * cell_c;
		wide   = q * a2 + dz2 * c2;
		d2     = wide[127:64];

		// residual as sign and magnitude
		tgt = {8'd0, target, 8'd0};
		neg = d2 < tgt;
		mag = neg ? tgt - d2 : d2 - tgt;

		// derivative factors 2*q*a and 2*dz^2*c
		wide = q * cell_a;
		da   = wide[106:43];
		wide = dz2 * cell_c;
		dc   = wide[106:43];

		// target term w*r^2 with clamping
		wide = weight * mag * mag;
		wide = wide >> 48;
		if (wide > POS_MAX) begin
			ov   = 1'b1;
			term = POS_MAX;
		end else begin
			term = wide[63:0];
		end
		sum_target = sum_target + term;
		if (sum_target > POS_MAX) begin
			ov         = 1'b1;
			sum_target = POS_MAX;
		end

		// gradient terms, each formed before it is added
		w_mag      = weight * mag;
		term       = slope_term(w_mag, da, neg, ov);
		sum_grad_a = clamp_add(sum_grad_a, term, ov);
		term       = slope_term(w_mag, dc, neg, ov);
		sum_grad_c = clamp_add(sum_grad_c, term, ov);
		sat_flag   = sat_flag | ov;

		if (!last)
			return 1'b0;
		sums.target_sum = sum_target[62:0];
		sums.grad_a     = sum_grad_a;
		sums.grad_c     = sum_grad_c;
		sums.overflow   = sat_flag;
		sum_target = '0;
		sum_grad_a = '0;
		sum_grad_c = '0;
		sat_flag   = 1'b0;
		return 1'b1;
	endfunction

	// Track registers, predict on each restraint word, compare each result word
	always @(posedge clk or negedge arst_n) begin
		set_sums_t sums;
		set_sums_t want;
		if (!arst_n) begin
			cell_a      = CELL_ONE;
			cell_c      = CELL_ONE;
			sum_target  = '0;
			sum_grad_a  = '0;
			sum_grad_c  = '0;
			sat_flag    = 1'b0;
			expected_sums.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CELL_A: cell_a = cfg_data;
					REG_CELL_C: cell_c = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (fold_restraint(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
						s_tdata[143:96], s_tdata[175:144], s_tlast, sums))
					expected_sums.push_back(sums);
			end
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					$error("result word with no set pending");
					failures++;
				end else begin
					want = expected_sums.pop_front();
					if (m_tdata[62:0] !== want.target_sum) begin
						$error("target_sum: expected %0d, got %0d",
							want.target_sum, m_tdata[62:0]);
						failures++;
					end
					if (m_tdata[126:63] !== want.grad_a) begin
						$error("grad_a: expected %0d, got %0d",
							want.grad_a, $signed(m_tdata[126:63]));
						failures++;
					end
					if (m_tdata[190:127] !== want.grad_c) begin
						$error("grad_c: expected %0d, got %0d",
							want.grad_c, $signed(m_tdata[190:127]));
						failures++;
					end
					if (m_tdata[191] !== 1'b0) begin
						$error("pad: expected 0, got %b", m_tdata[191]);
						failures++;
					end
					if (m_tuser !== want.overflow) begin
						$error("overflow: expected %b, got %b", want.overflow, m_tuser);
						failures++;
					end
				end
			end
			outstanding = expected_sums.size();
		end
	end

endmodule

// ===== sim/hexagonal_cell_restraint_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexagonal_cell_restraint_accumulator_tb: restraint accumulator testbench
// Drives register writes and restraint sets into the accumulator with random
// idle cycles on both streams. A directed part hits zero, exact and extreme
// restraints and saturation of terms and sums; the random part runs mostly
// plausible restraint sets under several cell settings, extremes included.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module hexagonal_cell_restraint_accumulator_tb;
	import hcra_pkg::*;

	localparam int unsigned IDLE_PCT        = 28;
	localparam int unsigned SETTLE_CYCLES   = 200;
	localparam int unsigned QUIET_LIMIT     = 2000;
	localparam int unsigned PHASE_ITEMS     = 80;
	localparam int unsigned PHASES          = 5;
	localparam int unsigned CALM_PHASE      = 3;
	localparam int unsigned PAUSE_PHASE     = 1;
	localparam logic [31:0] ONE_Q28         = 32'h1000_0000;
	localparam logic [47:0] ONE_Q24         = 48'h00_0001_000000;
	localparam logic [31:0] ONE_Q16         = 32'h0001_0000;
	localparam logic [31:0] ONE_Q20         = 32'h0010_0000;
	localparam logic [47:0] TARGET_MAX      = '1;
	localparam logic [31:0] WORD_MAX        = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;

	int                    failures;
	int                    outstanding;
	bit                    calm = 1'b0;
	int unsigned           quiet_cycles = 0;

	hexagonal_cell_restraint_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hcra_sums_checker u_sums_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result stream at random, never while calm
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one register word and hold it until taken
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Write both cell lengths with a dropped unknown index between them
	task automatic set_cell(input logic [31:0] len_a, input logic [31:0] len_c);
		write_reg(REG_CELL_A, len_a);
		write_reg(CFG_IDX_W'($urandom_range(REG_CELL_C + 1, {CFG_IDX_W{1'b1}})), $urandom);
		write_reg(REG_CELL_C, len_c);
		cfg_valid <= 1'b0;
	endtask

	// Present one restraint word after random idle cycles, hold until taken
	task automatic send_restraint(input logic [31:0] off_x, input logic [31:0] off_y,
			input logic [31:0] off_z, input logic [47:0] target,
			input logic [31:0] weight, input logic last);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {weight, target, off_z, off_y, off_x};
		s_tlast  <= last;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Plausible restraints stay near real geometry; noise spans the full fields
	task automatic send_random(input bit plausible, input logic last);
		logic [31:0] off [3];
		logic [31:0] mag;
		logic [47:0] target;
		logic [31:0] weight;
		for (int k = 0; k < 3; k++) begin
			if (plausible) begin
				mag    = $urandom_range(0, ONE_Q28 >> 1) >> $urandom_range(0, 8);
				off[k] = $urandom_range(0, 1) ? 32'd0 - mag : mag;
			end else begin
				off[k] = $urandom;
			end
		end
		if (plausible) begin
			target = 48'($urandom) >> $urandom_range(0, 12);
			weight = $urandom_range(0, ONE_Q16 << 2);
		end else begin
			target = 48'({$urandom, $urandom});
			weight = $urandom;
		end
		send_restraint(off[0], off[1], off[2], target, weight, last);
	endtask

	// Hold the sender until every set is back and the engine has gone quiet
	task automatic drain_sets();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] len_a;
		logic [31:0] len_c;
		int unsigned sent;
		int unsigned set_len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets at the reset cell lengths
		send_restraint('0, '0, '0, '0, '0, 1'b1);
		// residual exactly zero
		send_restraint(ONE_Q28, '0, '0, ONE_Q24, ONE_Q16, 1'b1);
		// positive and negative residual in one set
		send_restraint(ONE_Q28 >> 1, ONE_Q28 >> 2, 32'd0 - (ONE_Q28 >> 1), '0,
			ONE_Q16, 1'b0);
		send_restraint(32'd0 - (ONE_Q28 >> 2), ONE_Q28 >> 1, ONE_Q28 >> 3,
			ONE_Q24 << 1, ONE_Q16 << 1, 1'b1);
		// largest metric factor, opposite signs, full weight
		send_restraint(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0, WORD_MAX, 1'b1);
		// large negative residual
		send_restraint(32'h8000_0000, 32'h8000_0000, '0, TARGET_MAX, WORD_MAX, 1'b1);
		// smallest nonzero offsets
		send_restraint(WORD_MAX, 32'd1, WORD_MAX, 48'd1, 32'd1, 1'b1);
		// target sum saturates over three restraints, then a clean set
		repeat (2) send_restraint('0, '0, '0, ONE_Q24 << 7, WORD_MAX, 1'b0);
		send_restraint('0, '0, '0, ONE_Q24 << 7, WORD_MAX, 1'b1);
		send_restraint(ONE_Q28 >> 4, '0, ONE_Q28 >> 4, ONE_Q24, ONE_Q16, 1'b1);
		// alternating bit patterns
		send_restraint(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555,
			32'hAAAA_AAAA, 1'b0);
		send_restraint(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA,
			32'h5555_5555, 1'b1);
		// weight alone at full scale, then weight zero with a large residual
		send_restraint('0, '0, '0, '0, WORD_MAX, 1'b0);
		send_restraint(32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, '0, '0, 1'b1);
		drain_sets();

		// Random sets under several cell settings
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					len_a = ONE_Q20 * 10;
					len_c = ONE_Q20 * 25;
				end
				1: begin
					len_a = '0;
					len_c = '0;
				end
				2: begin
					len_a = WORD_MAX;
					len_c = WORD_MAX;
				end
				3: begin
					len_a = $urandom_range(ONE_Q20 * 2, ONE_Q20 * 60);
					len_c = $urandom_range(ONE_Q20 * 2, ONE_Q20 * 60);
				end
				default: begin
					len_a = $urandom;
					len_c = $urandom;
				end
			endcase
			set_cell(len_a, len_c);
			calm = (phase == CALM_PHASE);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				set_len = $urandom_range(1, 6);
				for (int unsigned k = 0; k < set_len; k++)
					send_random($urandom_range(99) >= 20, k == set_len - 1);
				sent += set_len;
				// one pause mid-phase until every set is back
				if (phase == PAUSE_PHASE && sent >= PHASE_ITEMS / 2
						&& sent < PHASE_ITEMS / 2 + set_len)
					drain_sets();
			end
			drain_sets();
		end
		calm = 1'b0;

		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hcra_pkg.sv
rtl/core/hcra_front.sv
rtl/core/hcra_queue.sv
rtl/core/hcra_engine.sv
rtl/core/hcra_sums.sv
rtl/core/hexagonal_cell_restraint_accumulator.sv
sim/hcra_sums_checker.sv
sim/hexagonal_cell_restraint_accumulator_tb.sv
